// ===== rtl/core/rle_pkg.sv =====
package rle_pkg;

   // Encoding constants of the run-length format.
   localparam logic [7:0] RUN_FLAG = 8'h80;
   localparam logic [7:0] RUN_MAX  = 8'd130;
   localparam logic [7:0] RUN_MIN  = 8'd3;

   // The result item has four byte fields, whatever the lane setting.
   localparam int BYTE_FIELDS = 4;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLOSE,
      ST_PUSH,
      ST_FLUSH_HDR,
      ST_FLUSH_DATA,
      ST_RUN_HDR,
      ST_RUN_VAL,
      ST_APPEND,
      ST_TAIL,
      ST_EOB,
      ST_FINISH
   } rle_state_type;

   // Which part of the request the sequencer is working on.
   typedef enum logic [1:0] {
      PH_MAIN_CLOSE,
      PH_CAP,
      PH_EOB_CLOSE
   } rle_phase_type;

   // One encoded byte, or the end-of-request marker, toward the packer.
   typedef struct packed {
      logic       valid;
      logic [7:0] data;
      logic       finish;
   } rle_emit_type;

   typedef struct packed {
      logic byte_ready;
      logic finish_ready;
   } rle_sink_type;

endpackage

// ===== rtl/core/rle_lit_ram.sv =====
module rle_lit_ram #(
   parameter int DEPTH  = 128,
   parameter int ADDR_W = 7
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [7:0]        wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [7:0]        rd_data
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/rle_seq.sv =====
module rle_seq #(
   parameter int LITERAL_CHUNK = 128,
   parameter int CNT_W         = 8,
   parameter int ADDR_W        = 7
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [7:0]           req_in_byte,
   input  logic                 req_end_of_block,
   input  rle_pkg::rle_sink_type sink,
   output rle_pkg::rle_emit_type emit,
   output logic                 wr_en,
   output logic [ADDR_W-1:0]    wr_addr,
   output logic [7:0]           wr_data,
   output logic                 rd_en,
   output logic [ADDR_W-1:0]    rd_addr,
   input  logic [7:0]           rd_data
);

   localparam logic [CNT_W-1:0] CHUNK = CNT_W'(LITERAL_CHUNK);

   rle_pkg::rle_state_type state_ff, state_in;
   rle_pkg::rle_state_type ret_ff, ret_in;
   rle_pkg::rle_state_type cont_state;
   rle_pkg::rle_phase_type phase_ff, phase_in;
   logic [7:0]       byte_ff, byte_in;
   logic             eob_ff, eob_in;
   logic [7:0]       run_value_ff, run_value_in;
   logic [7:0]       run_length_ff, run_length_in;
   logic [CNT_W-1:0] lit_count_ff, lit_count_in;
   logic [CNT_W-1:0] rd_idx_ff, rd_idx_in;
   logic [1:0]       push_left_ff, push_left_in;
   logic [7:0]       run_hdr_ff, run_hdr_in;
   logic [7:0]       run_out_ff, run_out_in;
   logic             close_now;
   logic             long_run;
   logic [CNT_W-1:0] count_inc;
   logic             push_full;
   logic [7:0]       length_inc;
   logic             cap_hit;

   always_comb begin
      unique case (phase_ff)
         rle_pkg::PH_MAIN_CLOSE: cont_state = rle_pkg::ST_APPEND;
         rle_pkg::PH_CAP:        cont_state = rle_pkg::ST_TAIL;
         rle_pkg::PH_EOB_CLOSE:  cont_state = rle_pkg::ST_EOB;
         default:                cont_state = rle_pkg::ST_APPEND;
      endcase
   end

   // At the end of a block any open run closes; otherwise only a new value closes it.
   assign close_now  = (run_length_ff != 8'd0) &&
                       ((phase_ff == rle_pkg::PH_EOB_CLOSE) || (byte_ff != run_value_ff));
   assign long_run   = run_length_ff >= rle_pkg::RUN_MIN;
   assign count_inc  = lit_count_ff + CNT_W'(1);
   assign push_full  = count_inc == CHUNK;
   assign length_inc = run_length_ff + 8'd1;
   assign cap_hit    = length_inc == rle_pkg::RUN_MAX;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rle_pkg::ST_IDLE: begin
            if (req_valid) state_in = rle_pkg::ST_CLOSE;
         end
         rle_pkg::ST_CLOSE: begin
            if (!close_now)    state_in = cont_state;
            else if (long_run) state_in = rle_pkg::ST_FLUSH_HDR;
            else               state_in = rle_pkg::ST_PUSH;
         end
         rle_pkg::ST_PUSH: begin
            if (push_full)                 state_in = rle_pkg::ST_FLUSH_HDR;
            else if (push_left_ff > 2'd1)  state_in = rle_pkg::ST_PUSH;
            else                           state_in = cont_state;
         end
         rle_pkg::ST_FLUSH_HDR: begin
            if (lit_count_ff == '0)   state_in = ret_ff;
            else if (sink.byte_ready) state_in = rle_pkg::ST_FLUSH_DATA;
         end
         rle_pkg::ST_FLUSH_DATA: begin
            if (sink.byte_ready && (rd_idx_ff == lit_count_ff)) state_in = ret_ff;
         end
         rle_pkg::ST_RUN_HDR: begin
            if (sink.byte_ready) state_in = rle_pkg::ST_RUN_VAL;
         end
         rle_pkg::ST_RUN_VAL: begin
            if (sink.byte_ready) state_in = cont_state;
         end
         rle_pkg::ST_APPEND: begin
            if (cap_hit) state_in = rle_pkg::ST_FLUSH_HDR;
            else         state_in = rle_pkg::ST_TAIL;
         end
         rle_pkg::ST_TAIL: begin
            if (eob_ff) state_in = rle_pkg::ST_CLOSE;
            else        state_in = rle_pkg::ST_FINISH;
         end
         rle_pkg::ST_EOB: begin
            state_in = rle_pkg::ST_FLUSH_HDR;
         end
         rle_pkg::ST_FINISH: begin
            if (sink.finish_ready) state_in = rle_pkg::ST_IDLE;
         end
         default: state_in = rle_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      ret_in        = ret_ff;
      phase_in      = phase_ff;
      byte_in       = byte_ff;
      eob_in        = eob_ff;
      run_value_in  = run_value_ff;
      run_length_in = run_length_ff;
      lit_count_in  = lit_count_ff;
      rd_idx_in     = rd_idx_ff;
      push_left_in  = push_left_ff;
      run_hdr_in    = run_hdr_ff;
      run_out_in    = run_out_ff;
      wr_en         = 1'b0;
      wr_addr       = lit_count_ff[ADDR_W-1:0];
      wr_data       = run_value_ff;
      rd_en         = 1'b0;
      rd_addr       = rd_idx_ff[ADDR_W-1:0];
      emit          = '0;
      req_ready     = 1'b0;
      unique case (state_ff)
         rle_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               byte_in  = req_in_byte;
               eob_in   = req_end_of_block;
               phase_in = rle_pkg::PH_MAIN_CLOSE;
            end
         end
         rle_pkg::ST_CLOSE: begin
            if (close_now) begin
               run_length_in = 8'd0;
               if (long_run) begin
                  run_hdr_in = rle_pkg::RUN_FLAG | (run_length_ff - rle_pkg::RUN_MIN);
                  run_out_in = run_value_ff;
                  ret_in     = rle_pkg::ST_RUN_HDR;
               end else begin
                  push_left_in = run_length_ff[1:0];
               end
            end
         end
         rle_pkg::ST_PUSH: begin
            wr_en        = 1'b1;
            lit_count_in = count_inc;
            push_left_in = push_left_ff - 2'd1;
            if (push_full) begin
               ret_in = (push_left_ff > 2'd1) ? rle_pkg::ST_PUSH : cont_state;
            end
         end
         rle_pkg::ST_FLUSH_HDR: begin
            if ((lit_count_ff != '0) && sink.byte_ready) begin
               emit.valid = 1'b1;
               emit.data  = 8'(lit_count_ff - CNT_W'(1));
               rd_en      = 1'b1;
               rd_addr    = '0;
               rd_idx_in  = CNT_W'(1);
            end
         end
         rle_pkg::ST_FLUSH_DATA: begin
            if (sink.byte_ready) begin
               emit.valid = 1'b1;
               emit.data  = rd_data;
               if (rd_idx_ff == lit_count_ff) begin
                  lit_count_in = '0;
               end else begin
                  rd_en     = 1'b1;
                  rd_idx_in = rd_idx_ff + CNT_W'(1);
               end
            end
         end
         rle_pkg::ST_RUN_HDR: begin
            if (sink.byte_ready) begin
               emit.valid = 1'b1;
               emit.data  = run_hdr_ff;
            end
         end
         rle_pkg::ST_RUN_VAL: begin
            if (sink.byte_ready) begin
               emit.valid = 1'b1;
               emit.data  = run_out_ff;
            end
         end
         rle_pkg::ST_APPEND: begin
            run_value_in = byte_ff;
            if (cap_hit) begin
               // A full-length run goes out after any stored literals, and counting restarts.
               run_length_in = 8'd0;
               run_hdr_in    = rle_pkg::RUN_FLAG | (rle_pkg::RUN_MAX - rle_pkg::RUN_MIN);
               run_out_in    = byte_ff;
               phase_in      = rle_pkg::PH_CAP;
               ret_in        = rle_pkg::ST_RUN_HDR;
            end else begin
               run_length_in = length_inc;
            end
         end
         rle_pkg::ST_TAIL: begin
            if (eob_ff) phase_in = rle_pkg::PH_EOB_CLOSE;
         end
         rle_pkg::ST_EOB: begin
            run_value_in = 8'd0;
            ret_in       = rle_pkg::ST_FINISH;
         end
         rle_pkg::ST_FINISH: begin
            emit.finish = 1'b1;
         end
         default: begin
            emit = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= rle_pkg::ST_IDLE;
         ret_ff        <= rle_pkg::ST_IDLE;
         phase_ff      <= rle_pkg::PH_MAIN_CLOSE;
         run_value_ff  <= 8'd0;
         run_length_ff <= 8'd0;
         lit_count_ff  <= '0;
         push_left_ff  <= 2'd0;
         rd_idx_ff     <= '0;
      end else begin
         state_ff      <= state_in;
         ret_ff        <= ret_in;
         phase_ff      <= phase_in;
         run_value_ff  <= run_value_in;
         run_length_ff <= run_length_in;
         lit_count_ff  <= lit_count_in;
         push_left_ff  <= push_left_in;
         rd_idx_ff     <= rd_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff    <= byte_in;
      eob_ff     <= eob_in;
      run_hdr_ff <= run_hdr_in;
      run_out_ff <= run_out_in;
   end

   a_idle_count_below_chunk : assert property (@(posedge clock) disable iff (reset)
      (state_ff == rle_pkg::ST_IDLE) |-> (lit_count_ff < CHUNK))
      else $error("literal count reached the chunk size between requests");

   a_run_below_cap : assert property (@(posedge clock) disable iff (reset)
      run_length_ff < rle_pkg::RUN_MAX)
      else $error("run length reached the cap without being emitted");

   a_write_in_range : assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (lit_count_ff < CHUNK) && !rd_en)
      else $error("literal write out of range or colliding with a read");

   a_read_index_valid : assert property (@(posedge clock) disable iff (reset)
      (state_ff == rle_pkg::ST_FLUSH_DATA) |->
         (rd_idx_ff != '0) && (rd_idx_ff <= lit_count_ff))
      else $error("literal read index outside the filled part of the store");

endmodule

// ===== rtl/core/rle_packer.sv =====
module rle_packer #(
   parameter int OUT_LANES = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  rle_pkg::rle_emit_type emit,
   output rle_pkg::rle_sink_type sink,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [7:0]            rsp_out_byte0,
   output logic [7:0]            rsp_out_byte1,
   output logic [7:0]            rsp_out_byte2,
   output logic [7:0]            rsp_out_byte3,
   output logic [2:0]            rsp_out_count,
   output logic                  rsp_out_final
);

   localparam int LANES  = (OUT_LANES > rle_pkg::BYTE_FIELDS) ? rle_pkg::BYTE_FIELDS
                                                              : OUT_LANES;
   localparam int ACNT_W = $clog2(LANES + 1);
   localparam int LANE_W = (LANES > 1) ? $clog2(LANES) : 1;
   localparam logic [ACNT_W-1:0] FULL = ACNT_W'(LANES);

   logic [7:0]        acc_ff [LANES];
   logic [ACNT_W-1:0] acc_cnt_ff, acc_cnt_in;
   logic [7:0]        acc_pad [rle_pkg::BYTE_FIELDS];
   logic [7:0]        out_byte_ff [rle_pkg::BYTE_FIELDS];
   logic [7:0]        out_byte_in [rle_pkg::BYTE_FIELDS];
   logic [2:0]        out_count_ff, out_count_in;
   logic              out_final_ff, out_final_in;
   logic              out_valid_ff, out_valid_in;
   logic              acc_full;
   logic              out_free;
   logic              load;

   for (genvar g = 0; g < rle_pkg::BYTE_FIELDS; g++) begin : g_pad
      if (g < LANES) begin : g_lane
         assign acc_pad[g] = (ACNT_W'(g) < acc_cnt_ff) ? acc_ff[g] : 8'd0;
      end else begin : g_none
         assign acc_pad[g] = 8'd0;
      end
   end

   assign acc_full          = acc_cnt_ff == FULL;
   assign out_free          = !out_valid_ff || rsp_ready;
   assign sink.byte_ready   = !acc_full || out_free;
   assign sink.finish_ready = (acc_cnt_ff == '0) || out_free;

   // A full group is held back until the next byte shows it is not the last.
   assign load = (emit.valid && acc_full) ||
                 (emit.finish && (acc_cnt_ff != '0) && out_free);

   always_comb begin
      acc_cnt_in   = acc_cnt_ff;
      out_count_in = out_count_ff;
      out_final_in = out_final_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      for (int j = 0; j < rle_pkg::BYTE_FIELDS; j++) begin
         out_byte_in[j] = out_byte_ff[j];
      end
      if (load) begin
         out_valid_in = 1'b1;
         out_count_in = 3'(acc_cnt_ff);
         out_final_in = emit.finish;
         for (int j = 0; j < rle_pkg::BYTE_FIELDS; j++) begin
            out_byte_in[j] = acc_pad[j];
         end
      end
      if (emit.valid) begin
         acc_cnt_in = acc_full ? ACNT_W'(1) : acc_cnt_ff + ACNT_W'(1);
      end else if (emit.finish && load) begin
         acc_cnt_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit.valid) begin
         if (acc_full) begin
            acc_ff[0] <= emit.data;
         end else begin
            acc_ff[acc_cnt_ff[LANE_W-1:0]] <= emit.data;
         end
      end
      for (int j = 0; j < rle_pkg::BYTE_FIELDS; j++) begin
         out_byte_ff[j] <= out_byte_in[j];
      end
      out_count_ff <= out_count_in;
      out_final_ff <= out_final_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_cnt_ff   <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         acc_cnt_ff   <= acc_cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_out_byte0 = out_byte_ff[0];
   assign rsp_out_byte1 = out_byte_ff[1];
   assign rsp_out_byte2 = out_byte_ff[2];
   assign rsp_out_byte3 = out_byte_ff[3];
   assign rsp_out_count = out_count_ff;
   assign rsp_out_final = out_final_ff;

   a_byte_only_when_ready : assert property (@(posedge clock) disable iff (reset)
      emit.valid |-> sink.byte_ready && !emit.finish)
      else $error("encoded byte offered while the packer cannot take it");

   a_count_in_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_out_count != 3'd0) && (rsp_out_count <= 3'(LANES)))
      else $error("result byte count outside the lane range");

   a_partial_only_final : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_out_count != 3'(LANES))) |-> rsp_out_final)
      else $error("partly filled result that is not the last of its request");

endmodule

// ===== rtl/core/rle_byte_encoder_core.sv =====
// Requests are taken one at a time, and literal flushes stream the store out through its
// single read port one byte a cycle while the packer accepts bytes. A full output register
// stalls the sequencer once the packer's pending group has to move into it.
// Reset clears the run, the literal count, the sequencer and the output register;
// the literal store contents are not cleared and are only read below the count.
module rle_byte_encoder_core #(
   parameter int LITERAL_CHUNK = 128,
   parameter int OUT_LANES     = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_byte,
   input  logic       req_end_of_block,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte0,
   output logic [7:0] rsp_out_byte1,
   output logic [7:0] rsp_out_byte2,
   output logic [7:0] rsp_out_byte3,
   output logic [2:0] rsp_out_count,
   output logic       rsp_out_final
);

   localparam int CNT_W  = $clog2(LITERAL_CHUNK + 1);
   localparam int ADDR_W = (LITERAL_CHUNK > 1) ? $clog2(LITERAL_CHUNK) : 1;

   rle_pkg::rle_emit_type emit;
   rle_pkg::rle_sink_type sink;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [7:0]        wr_data;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [7:0]        rd_data;

   rle_seq #(
      .LITERAL_CHUNK (LITERAL_CHUNK),
      .CNT_W         (CNT_W),
      .ADDR_W        (ADDR_W)
   ) u_seq (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_in_byte      (req_in_byte),
      .req_end_of_block (req_end_of_block),
      .sink             (sink),
      .emit             (emit),
      .wr_en            (wr_en),
      .wr_addr          (wr_addr),
      .wr_data          (wr_data),
      .rd_en            (rd_en),
      .rd_addr          (rd_addr),
      .rd_data          (rd_data)
   );

   rle_lit_ram #(
      .DEPTH  (LITERAL_CHUNK),
      .ADDR_W (ADDR_W)
   ) u_lit_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   rle_packer #(
      .OUT_LANES (OUT_LANES)
   ) u_packer (
      .clock         (clock),
      .reset         (reset),
      .emit          (emit),
      .sink          (sink),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_byte0 (rsp_out_byte0),
      .rsp_out_byte1 (rsp_out_byte1),
      .rsp_out_byte2 (rsp_out_byte2),
      .rsp_out_byte3 (rsp_out_byte3),
      .rsp_out_count (rsp_out_count),
      .rsp_out_final (rsp_out_final)
   );

endmodule
